// ----- src/mlc_pkg.sv -----
// Shared constants, types and the logarithm table of the mu/A-law compressor.
// Used by every module under src; depends on nothing.
package mlc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int K_W       = 16;
  localparam int FS_W      = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LAW_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAW_CONSTANT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 2'd2;

  localparam logic LAW_MU = 1'b0;
  localparam logic LAW_A  = 1'b1;

  localparam logic [K_W-1:0]  K_ONE  = 16'd256;
  localparam logic [FS_W-1:0] FS_ONE = 15'd1;

  // Q16 fixed point
  localparam int             FRAC_W  = 16;
  localparam logic [20:0]    ONE_Q16 = 21'd65536;
  localparam logic [15:0]    LN2_Q16 = 16'd45426;

  // logarithm unit
  localparam int LN_IN_W  = 40;
  localparam int LN_OUT_W = 21;
  localparam int LN_GW    = 8;
  localparam int LN_GROUPS = LN_IN_W / LN_GW;
  localparam int LN_POS_W = $clog2(LN_IN_W);
  localparam int LN_EXP_W = 5;
  localparam int LN_LAT   = 6;

  localparam int LOG_DEPTH = 256;
  localparam int LOG_AW    = $clog2(LOG_DEPTH);

  // divider widths, used by both dividers
  localparam int DIV_N_W = 39;
  localparam int DIV_D_W = 21;

  typedef struct packed {
    logic neg;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic              below_one;
    logic [FRAC_W-1:0] ulo;
  } side_t;

  typedef logic [FRAC_W-1:0] log_rom_t [0:LOG_DEPTH];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/D) in Q16 through 2*atanh(i/(2D+i)), series in Q30
  function automatic log_rom_t build_log_rom();
    log_rom_t        rom;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned kk;
    for (int i = 0; i <= LOG_DEPTH; i++) begin
      z    = udiv(longint'(i) << 30, longint'(2 * LOG_DEPTH + i));
      z2   = (z * z) >> 30;
      term = z;
      sum  = 0;
      kk   = 1;
      for (int n = 0; n < 64; n++) begin
        if (term != 0) begin
          sum  = sum + udiv(term, kk);
          term = (term * z2) >> 30;
          kk   = kk + 2;
        end
      end
      rom[i] = FRAC_W'((2 * sum + (64'd1 << 13)) >> 14);
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// ----- src/mlc_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on mlc_pkg for widths and the tag type.
module mlc_div
  import mlc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  tag_t               in_tag,
  input  logic [DIV_N_W-1:0] in_num,
  input  logic [DIV_D_W-1:0] in_den,
  output logic               out_valid,
  output tag_t               out_tag,
  output logic [DIV_N_W-1:0] out_quo
);

  logic               v_r   [DIV_N_W];
  tag_t               tag_r [DIV_N_W];
  logic [DIV_N_W-1:0] a_r   [DIV_N_W];
  logic [DIV_D_W-1:0] rem_r [DIV_N_W];
  logic [DIV_D_W-1:0] d_r   [DIV_N_W];

  for (genvar s = 0; s < DIV_N_W; s++) begin : g_stage
    logic               v_in;
    tag_t               tag_in;
    logic [DIV_N_W-1:0] a_in;
    logic [DIV_D_W-1:0] rem_in;
    logic [DIV_D_W-1:0] d_in;
    logic [DIV_D_W:0]   sh;
    logic               ge;
    logic [DIV_D_W:0]   diff;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign tag_in = in_tag;
      assign a_in   = in_num;
      assign rem_in = '0;
      assign d_in   = in_den;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign tag_in = tag_r[s-1];
      assign a_in   = a_r[s-1];
      assign rem_in = rem_r[s-1];
      assign d_in   = d_r[s-1];
    end

    always_comb begin
      sh   = {rem_in, a_in[DIV_N_W-1]};
      ge   = sh >= {1'b0, d_in};
      diff = sh - {1'b0, d_in};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s] <= tag_in;
        d_r[s]   <= d_in;
        a_r[s]   <= {a_in[DIV_N_W-2:0], ge};
        rem_r[s] <= ge ? diff[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
      end
    end
  end

  assign out_valid = v_r[DIV_N_W-1];
  assign out_tag   = tag_r[DIV_N_W-1];
  assign out_quo   = a_r[DIV_N_W-1];

endmodule

// ----- src/mlc_ln.sv -----
// Six-stage natural logarithm of a Q16 value: leading-one search, normalize,
// table lookup and linear interpolation. Depends on mlc_pkg for the table.
module mlc_ln
  import mlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [LN_IN_W-1:0]  in_v,
  output logic                out_valid,
  output logic [LN_OUT_W-1:0] out_ln
);

  logic [LN_LAT-1:0] v_r;

  // stage 1: per-group leading one
  logic [LN_IN_W-1:0] s1_v_r;
  logic [LN_GROUPS-1:0] s1_nz_r, s1_nz_nxt;
  logic [2:0] s1_pos_r [LN_GROUPS];
  logic [2:0] s1_pos_nxt [LN_GROUPS];

  always_comb begin
    for (int g = 0; g < LN_GROUPS; g++) begin
      s1_nz_nxt[g]  = |in_v[g*LN_GW +: LN_GW];
      s1_pos_nxt[g] = '0;
      for (int b = 0; b < LN_GW; b++) begin
        if (in_v[g*LN_GW + b]) s1_pos_nxt[g] = 3'(b);
      end
    end
  end

  // stage 2: pick the highest group
  logic [LN_IN_W-1:0]  s2_v_r;
  logic [LN_POS_W-1:0] s2_p_r, s2_p_nxt;
  logic                s2_small_r, s2_small_nxt;

  always_comb begin
    s2_p_nxt = '0;
    for (int g = 0; g < LN_GROUPS; g++) begin
      if (s1_nz_r[g]) s2_p_nxt = LN_POS_W'(g * LN_GW) + LN_POS_W'(s1_pos_r[g]);
    end
    s2_small_nxt = (s1_nz_r == '0) || (s2_p_nxt < LN_POS_W'(FRAC_W));
  end

  // stage 3: normalize to a 16-bit fraction
  logic [FRAC_W-1:0]   s3_frac_r, s3_frac_nxt;
  logic [LN_EXP_W-1:0] s3_e_r, s3_e_nxt;
  logic                s3_small_r;
  logic [LN_IN_W-1:0]  s3_sh;

  always_comb begin
    s3_e_nxt    = s2_small_r ? '0 : LN_EXP_W'(s2_p_r - LN_POS_W'(FRAC_W));
    s3_sh       = s2_v_r >> s3_e_nxt;
    s3_frac_nxt = s3_sh[FRAC_W-1:0];
  end

  // stage 4: table lookup
  localparam int ADDR_W = FRAC_W + LOG_AW;
  logic [ADDR_W-1:0]   s4_addr;
  logic [LOG_AW:0]     s4_j;
  logic [FRAC_W-1:0]   s4_lo, s4_hi;
  logic [FRAC_W-1:0]   s4_lo_r, s4_diff_r, s4_r_r;
  logic [LN_OUT_W-1:0] s4_elog_r;
  logic                s4_small_r;

  always_comb begin
    s4_addr = ADDR_W'(s3_frac_r) * ADDR_W'(LOG_DEPTH);
    s4_j    = {1'b0, s4_addr[FRAC_W +: LOG_AW]};
    s4_lo   = LOG_ROM[s4_j];
    s4_hi   = LOG_ROM[s4_j + (LOG_AW+1)'(1)];
    if (s4_hi < s4_lo) s4_hi = s4_lo;
  end

  // stage 5: interpolation product
  logic [2*FRAC_W-1:0] s5_prod_r;
  logic [FRAC_W-1:0]   s5_lo_r;
  logic [LN_OUT_W-1:0] s5_elog_r;
  logic                s5_small_r;

  // stage 6: sum
  logic [LN_OUT_W-1:0]   s6_ln_r;
  logic [2*FRAC_W:0]     s6_round;

  always_comb begin
    s6_round = {1'b0, s5_prod_r} + (2*FRAC_W+1)'(33'd1 << (FRAC_W-1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LN_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v_r  <= in_v;
      s1_nz_r <= s1_nz_nxt;
      for (int g = 0; g < LN_GROUPS; g++) s1_pos_r[g] <= s1_pos_nxt[g];

      s2_v_r     <= s1_v_r;
      s2_p_r     <= s2_p_nxt;
      s2_small_r <= s2_small_nxt;

      s3_frac_r  <= s3_frac_nxt;
      s3_e_r     <= s3_e_nxt;
      s3_small_r <= s2_small_r;

      s4_lo_r    <= s4_lo;
      s4_diff_r  <= s4_hi - s4_lo;
      s4_r_r     <= s4_addr[FRAC_W-1:0];
      s4_elog_r  <= LN_OUT_W'(s3_e_r) * LN_OUT_W'(LN2_Q16);
      s4_small_r <= s3_small_r;

      s5_prod_r  <= {{FRAC_W{1'b0}}, s4_diff_r} * {{FRAC_W{1'b0}}, s4_r_r};
      s5_lo_r    <= s4_lo_r;
      s5_elog_r  <= s4_elog_r;
      s5_small_r <= s4_small_r;

      s6_ln_r <= s5_small_r ? '0 :
                 s5_elog_r + LN_OUT_W'(s5_lo_r) + LN_OUT_W'(s6_round[2*FRAC_W:FRAC_W]);
    end
  end

  assign out_valid = v_r[LN_LAT-1];
  assign out_ln    = s6_ln_r;

endmodule

// ----- src/mu_a_law_sample_compressor.sv -----
// Continuous mu-law / A-law sample compressor, top level.
// Depends on mlc_pkg, mlc_div and mlc_ln.
//
// Input channel in_valid/in_ready carries one signed sample per transfer;
// output channel out_valid/out_ready returns the compressed sample and a
// saturation flag, one result per input, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 law mode, 1 law
// constant Q8.8, 2 full scale) and cfg_data; cfg_ready is always high.
// Write configuration only while no sample is in flight.
// The pipeline holds input and product registers, a 39-stage divider for
// K*|x|/F, the 6-stage log unit, numerator and scaling registers, a second
// 39-stage divider by the log denominator, and the output register.
// Throughput is one sample per cycle unless the receiver stalls. The denominator
// comes from a second log unit that runs freely on the configuration registers.
// Reset clears the pipeline valid bits and loads mu-law, K = 1.0 and full
// scale 32767. When the receiver stalls, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module mu_a_law_sample_compressor
  import mlc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data
);

  logic            mode_r;
  logic [K_W-1:0]  kconst_r;
  logic [FS_W-1:0] fscale_r;
  logic [K_W-1:0]  k_eff;
  logic [FS_W-1:0] f_eff;
  logic            en;

  assign cfg_ready = 1'b1;
  assign k_eff     = (kconst_r < K_ONE) ? K_ONE : kconst_r;
  assign f_eff     = (fscale_r == '0) ? FS_ONE : fscale_r;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= LAW_MU;
      kconst_r <= K_ONE;
      fscale_r <= 15'd32767;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LAW_MODE:     mode_r   <= cfg_data[0];
        CFG_LAW_CONSTANT: kconst_r <= cfg_data;
        CFG_FULL_SCALE:   fscale_r <= cfg_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // denominator, recomputed every cycle from configuration
  logic [23:0]          kq;
  logic [LN_IN_W-1:0]   den_v;
  logic [LN_OUT_W-1:0]  den_ln;
  logic [LN_OUT_W-1:0]  den_raw;
  logic [DIV_D_W-1:0]   den_r;

  assign kq    = {k_eff, 8'b0};
  assign den_v = (mode_r == LAW_A) ? LN_IN_W'(kq) : LN_IN_W'(kq) + LN_IN_W'(ONE_Q16);

  mlc_ln u_den_ln (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (1'b1),
    .in_valid (1'b1),
    .in_v     (den_v),
    .out_valid(),
    .out_ln   (den_ln)
  );

  assign den_raw = (mode_r == LAW_A) ? den_ln + ONE_Q16 : den_ln;

  always_ff @(posedge clk) begin
    den_r <= (den_raw == '0) ? DIV_D_W'(1) : DIV_D_W'(den_raw);
  end

  // stage A: magnitude and sign
  logic                a_v_r;
  logic [SAMPLE_W-1:0] a_mag_r;
  tag_t                a_tag_r;

  // stage B: K * |x|
  logic                  b_v_r;
  logic [K_W+SAMPLE_W-1:0] b_prod_r;
  tag_t                  b_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r.neg <= in_sample_in[SAMPLE_W-1];
      a_mag_r     <= in_sample_in[SAMPLE_W-1] ? SAMPLE_W'(-in_sample_in)
                                              : SAMPLE_W'(in_sample_in);
      b_prod_r    <= (K_W+SAMPLE_W)'(k_eff) * (K_W+SAMPLE_W)'(a_mag_r);
      b_tag_r     <= a_tag_r;
    end
  end

  // u = K*|x|*256 / F
  logic               u_v;
  tag_t               u_tag;
  logic [DIV_N_W-1:0] u_q;

  mlc_div u_div_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_v_r),
    .in_tag   (b_tag_r),
    .in_num   ({b_prod_r[DIV_N_W-9:0], 8'b0}),
    .in_den   (DIV_D_W'(f_eff)),
    .out_valid(u_v),
    .out_tag  (u_tag),
    .out_quo  (u_q)
  );

  // numerator log, with side data kept in step
  logic [LN_IN_W-1:0]  num_v;
  logic                ln_v;
  logic [LN_OUT_W-1:0] ln_q;
  side_t               side_r [LN_LAT];
  side_t               side_nxt;

  assign num_v = (mode_r == LAW_A) ? LN_IN_W'(u_q) : LN_IN_W'(u_q) + LN_IN_W'(ONE_Q16);

  always_comb begin
    side_nxt.tag       = u_tag;
    side_nxt.below_one = u_q < DIV_N_W'(ONE_Q16);
    side_nxt.ulo       = u_q[FRAC_W-1:0];
  end

  mlc_ln u_num_ln (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (u_v),
    .in_v     (num_v),
    .out_valid(ln_v),
    .out_ln   (ln_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < LN_LAT; s++) side_r[s] <= side_r[s-1];
    end
  end

  // stage D: numerator select; stage E: F * num + den/2
  logic                d_v_r;
  logic [LN_OUT_W-1:0] d_num_r, d_num_nxt;
  tag_t                d_tag_r;
  logic                e_v_r;
  logic [DIV_N_W-1:0]  e_dvd_r;
  tag_t                e_tag_r;

  always_comb begin
    if (mode_r == LAW_A) begin
      d_num_nxt = side_r[LN_LAT-1].below_one ? LN_OUT_W'(side_r[LN_LAT-1].ulo)
                                             : ln_q + ONE_Q16;
    end else begin
      d_num_nxt = ln_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= ln_v;
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num_r <= d_num_nxt;
      d_tag_r <= side_r[LN_LAT-1].tag;
      e_dvd_r <= DIV_N_W'(f_eff) * DIV_N_W'(d_num_r) + DIV_N_W'(den_r >> 1);
      e_tag_r <= d_tag_r;
    end
  end

  logic               y_v;
  tag_t               y_tag;
  logic [DIV_N_W-1:0] y_q;

  mlc_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (e_v_r),
    .in_tag   (e_tag_r),
    .in_num   (e_dvd_r),
    .in_den   (den_r),
    .out_valid(y_v),
    .out_tag  (y_tag),
    .out_quo  (y_q)
  );

  // saturate, apply sign, hold for the receiver
  logic                out_v_r;
  logic [SAMPLE_W-1:0] out_s_r;
  logic                out_sat_r;
  logic [DIV_N_W-1:0]  limit;
  logic [DIV_N_W-1:0]  y_c;
  logic                sat;

  always_comb begin
    limit = y_tag.neg ? DIV_N_W'(1) << (SAMPLE_W-1) : (DIV_N_W'(1) << (SAMPLE_W-1)) - 1'b1;
    sat   = y_q > limit;
    y_c   = sat ? limit : y_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= y_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s_r   <= y_tag.neg ? SAMPLE_W'(-y_c) : y_c[SAMPLE_W-1:0];
      out_sat_r <= sat;
    end
  end

  assign out_valid      = out_v_r;
  assign out_sample_out = out_s_r;
  assign out_saturated  = out_sat_r;

endmodule
